// ===== hw/rtl/wtp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wtp_pkg
// Shared types and constants of the waypoint time parameterizer.
// ----------------------------------------------------------------------------
package wtp_pkg;
	localparam int unsigned JOINT_COUNT = 6;
	localparam int unsigned POS_W    = 24;
	localparam int unsigned DELTA_W  = 25;
	localparam int unsigned MAG_W    = 24;
	localparam int unsigned REG_W    = 17;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned VEL_W    = 32;
	localparam int unsigned DIV_W    = 41;
	localparam logic [REG_W-1:0] SCALE_MIN = 17'd3277;
	localparam logic [REG_W-1:0] SCALE_MAX = 17'd65536;
	localparam logic [REG_W-1:0] MIN_STEP_RESET = 17'd1311;
	localparam logic CFG_SCALE   = 1'b0;
	localparam logic CFG_MINSTEP = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture request and compute deltas
		logic first;     // load is for a first point
		logic div_start; // start a division
		logic div_dt;    // division is dt; otherwise velocity of sel joint
		logic find_max;  // fold one joint into max magnitude
		logic set_dt;    // latch dt after its division
		logic store_vel; // latch velocity of sel joint
		logic commit;    // update time and previous positions
	} wtp_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic dt_zero;
	} wtp_stat_t;
endpackage
`default_nettype wire

// ===== hw/rtl/waypoint_time_parameterizer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// waypoint_time_parameterizer
// Step time and joint velocities for a stream of waypoints.
// ----------------------------------------------------------------------------
// One waypoint at a time. A first point goes from acceptance through S_VELW,
// where it commits, to its result. Any other point runs a max search over
// the joints, then one shared 41-bit restoring divider, one quotient bit per
// cycle, does the dt division and one division per joint. When dt is zero the
// joint divisions are skipped. The next request is taken in the cycle its
// result is taken, so a stalled result stalls the input.
module waypoint_time_parameterizer import wtp_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic                cfg_index,
	input  wire logic [REG_W-1:0]    cfg_data,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic                first_point,
	input  wire logic [POS_W-1:0]    joint_pos_0,
	input  wire logic [POS_W-1:0]    joint_pos_1,
	input  wire logic [POS_W-1:0]    joint_pos_2,
	input  wire logic [POS_W-1:0]    joint_pos_3,
	input  wire logic [POS_W-1:0]    joint_pos_4,
	input  wire logic [POS_W-1:0]    joint_pos_5,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [TIME_W-1:0]        elapsed_time,
	output logic [VEL_W-1:0]         joint_vel_0,
	output logic [VEL_W-1:0]         joint_vel_1,
	output logic [VEL_W-1:0]         joint_vel_2,
	output logic [VEL_W-1:0]         joint_vel_3,
	output logic [VEL_W-1:0]         joint_vel_4,
	output logic [VEL_W-1:0]         joint_vel_5
);
	localparam int unsigned SEL_W = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
	logic [REG_W-1:0] scale_q, minstep_q;
	logic [JOINT_COUNT-1:0][POS_W-1:0] pos;
	logic [JOINT_COUNT-1:0][VEL_W-1:0] vel;
	wtp_cmd_t cmd;
	wtp_stat_t stat;
	logic [SEL_W-1:0] sel;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q   <= SCALE_MAX;
			minstep_q <= MIN_STEP_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SCALE:   scale_q   <= cfg_data;
				CFG_MINSTEP: minstep_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign pos = {joint_pos_5, joint_pos_4, joint_pos_3, joint_pos_2,
	              joint_pos_1, joint_pos_0};
	assign joint_vel_0 = vel[0];
	assign joint_vel_1 = vel[1];
	assign joint_vel_2 = vel[2];
	assign joint_vel_3 = vel[3];
	assign joint_vel_4 = vel[4];
	assign joint_vel_5 = vel[5];

	wtp_ctrl #(.NUM_JOINTS(JOINT_COUNT), .SEL_W(SEL_W)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_first(first_point),
		.in_ready(in_ready), .out_valid(out_valid), .out_ready(out_ready),
		.stat(stat), .cmd(cmd), .sel(sel)
	);

	wtp_datapath #(.NUM_JOINTS(JOINT_COUNT), .SEL_W(SEL_W)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sel(sel), .pos(pos),
		.scale_cfg(scale_q), .min_step(minstep_q), .stat(stat),
		.time_q(elapsed_time), .vel_q(vel)
	);
endmodule
`default_nettype wire

// ===== hw/rtl/wtp_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wtp_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wtp_div import wtp_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DIV_W-1:0]  num,
	input  wire logic [TIME_W-1:0] den,
	output logic                   busy,
	output logic [DIV_W-1:0]       quo
);
	localparam int unsigned CNT_W = $clog2(DIV_W + 1);
	logic [CNT_W-1:0]  cnt_q;
	logic [DIV_W-1:0]  n_q;
	logic [TIME_W-1:0] d_q;
	logic [TIME_W-1:0] rem_q;
	logic [TIME_W:0]   trial;
	logic [TIME_W:0]   diff;

	// rem < den, so trial - den always fits a 33-bit signed value
	assign trial = {rem_q, n_q[DIV_W-1]};
	assign diff  = trial - {1'b0, d_q};
	assign busy  = (cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(DIV_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num;
			d_q   <= den;
			rem_q <= '0;
			quo   <= '0;
		end else if (busy) begin
			n_q <= {n_q[DIV_W-2:0], 1'b0};
			if (!diff[TIME_W]) begin
				rem_q <= diff[TIME_W-1:0];
				quo   <= {quo[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[TIME_W-1:0];
				quo   <= {quo[DIV_W-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/wtp_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wtp_datapath
// Deltas, max magnitude, dt, time accumulation and velocity saturation.
// ----------------------------------------------------------------------------
module wtp_datapath import wtp_pkg::*; #(
	parameter int unsigned NUM_JOINTS = 6,
	parameter int unsigned SEL_W = 3
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire wtp_cmd_t                        cmd,
	input  wire logic [SEL_W-1:0]                sel,
	input  wire logic [NUM_JOINTS-1:0][POS_W-1:0] pos,
	input  wire logic [REG_W-1:0]                scale_cfg,
	input  wire logic [REG_W-1:0]                min_step,
	output wtp_stat_t                            stat,
	output logic [TIME_W-1:0]                    time_q,
	output logic [NUM_JOINTS-1:0][VEL_W-1:0]     vel_q
);
	logic [NUM_JOINTS-1:0][POS_W-1:0]   prev_q;
	logic [NUM_JOINTS-1:0][POS_W-1:0]   cur_q;
	logic [NUM_JOINTS-1:0][DELTA_W-1:0] delta_q;
	logic [TIME_W-1:0]                  prev_time_q;
	logic [MAG_W-1:0]                   max_q;
	logic [TIME_W-1:0]                  dt_q;
	logic [REG_W-1:0]                   scale;
	logic [DIV_W-1:0]                   num, quo;
	logic [TIME_W-1:0]                  den;
	logic [DELTA_W-1:0]                 dsel;
	logic [MAG_W-1:0]                   mag;
	logic                               busy;
	logic [TIME_W:0]                    tsum;
	logic [TIME_W-1:0]                  tnext;

	always_comb begin
		if (scale_cfg < SCALE_MIN) scale = SCALE_MIN;
		else if (scale_cfg > SCALE_MAX) scale = SCALE_MAX;
		else scale = scale_cfg;
	end

	assign dsel = delta_q[sel];
	assign mag  = dsel[DELTA_W-1] ? MAG_W'(-dsel) : dsel[MAG_W-1:0];

	always_comb begin
		if (cmd.div_dt) begin
			den = TIME_W'(scale);
			num = {1'b0, max_q, 16'd0} + DIV_W'(scale >> 1);
		end else begin
			den = dt_q;
			num = {1'b0, mag, 16'd0} + DIV_W'(dt_q >> 1);
		end
	end

	wtp_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(num), .den(den), .busy(busy), .quo(quo)
	);

	assign stat.div_busy = busy;
	assign stat.dt_zero  = (dt_q == '0);
	assign tsum  = {1'b0, prev_time_q} + {1'b0, dt_q};
	assign tnext = tsum[TIME_W] ? '1 : tsum[TIME_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			prev_time_q <= '0;
		end else if (cmd.commit) begin
			prev_q      <= cur_q;
			prev_time_q <= cmd.first ? '0 : tnext;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q <= pos;
			max_q <= '0;
			for (int j = 0; j < NUM_JOINTS; j++) begin
				delta_q[j] <= DELTA_W'($signed(pos[j])) - DELTA_W'($signed(prev_q[j]));
			end
			if (cmd.first) begin
				time_q <= '0;
				vel_q  <= '0;
			end
		end
		if (cmd.find_max && mag > max_q) max_q <= mag;
		if (cmd.set_dt) begin
			if (quo[DIV_W-1:TIME_W] == '0 && quo[TIME_W-1:0] >= TIME_W'(min_step))
				dt_q <= quo[TIME_W-1:0];
			else if (quo[DIV_W-1:TIME_W] != '0)
				dt_q <= '1;
			else
				dt_q <= TIME_W'(min_step);
		end
		if (cmd.commit && !cmd.first) begin
			time_q <= tnext;
		end
		if (cmd.store_vel) begin
			if (dt_q == '0) begin
				vel_q[sel] <= '0;
			end else if (dsel[DELTA_W-1]) begin
				vel_q[sel] <= (quo > DIV_W'(33'h80000000)) ? 32'h80000000
				            : VEL_W'(-quo[VEL_W-1:0]);
			end else begin
				vel_q[sel] <= (quo > DIV_W'(32'h7FFFFFFF)) ? 32'h7FFFFFFF
				            : quo[VEL_W-1:0];
			end
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/wtp_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wtp_ctrl
// Sequencer: load, max search, dt division, per-joint velocity divisions.
// ----------------------------------------------------------------------------
module wtp_ctrl import wtp_pkg::*; #(
	parameter int unsigned NUM_JOINTS = 6,
	parameter int unsigned SEL_W = 3
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             in_first,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire wtp_stat_t        stat,
	output wtp_cmd_t              cmd,
	output logic [SEL_W-1:0]      sel
);
	typedef enum logic [2:0] {
		S_IDLE, S_MAX, S_DT, S_DTW, S_VEL, S_VELW, S_OUT
	} state_t;
	state_t state_q;
	logic [SEL_W-1:0] sel_q;
	logic first_q;
	logic last;

	assign sel = sel_q;
	assign last = (sel_q == SEL_W'(NUM_JOINTS - 1));
	assign in_ready  = (state_q == S_IDLE) || (state_q == S_OUT && out_ready);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd = '0;
		cmd.first = first_q;
		unique case (state_q)
			S_IDLE, S_OUT: begin
				cmd.load  = in_valid && in_ready;
				cmd.first = in_first;
			end
			S_MAX: cmd.find_max = 1'b1;
			S_DT: begin
				cmd.div_start = 1'b1;
				cmd.div_dt    = 1'b1;
			end
			S_DTW: begin
				cmd.div_dt = 1'b1;
				cmd.set_dt = !stat.div_busy;
			end
			S_VEL: cmd.div_start = !stat.dt_zero;
			S_VELW: begin
				// a first point keeps the zero velocities from its load
				cmd.store_vel = !stat.div_busy && !first_q;
				cmd.commit    = !stat.div_busy && last;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q   <= '0;
			first_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE, S_OUT: begin
					if (in_valid && in_ready) begin
						first_q <= in_first;
						sel_q   <= in_first ? SEL_W'(NUM_JOINTS - 1) : '0;
						state_q <= in_first ? S_VELW : S_MAX;
					end else if (state_q == S_OUT && out_ready) begin
						state_q <= S_IDLE;
					end
				end
				S_MAX: begin
					if (last) begin
						state_q <= S_DT;
						sel_q   <= '0;
					end else begin
						sel_q <= sel_q + 1'b1;
					end
				end
				S_DT:  state_q <= S_DTW;
				S_DTW: if (!stat.div_busy) state_q <= S_VEL;
				S_VEL: state_q <= S_VELW;
				S_VELW: begin
					if (!stat.div_busy) begin
						if (last) begin
							state_q <= S_OUT;
						end else begin
							sel_q   <= sel_q + 1'b1;
							state_q <= S_VEL;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MAX || state_q == S_DTW || state_q == S_VELW) |-> !in_ready)
		else $error("accept while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result dropped");
	a_dt_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DT) |=> stat.div_busy)
		else $error("divider did not start");
endmodule
`default_nettype wire
